>>> design/txtscr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txtscr_pkg
// Constants shared by the text screen terminal: geometry, cell codes and
// control character codes.
// ----------------------------------------------------------------------------
package txtscr_pkg;

  localparam int DEFAULT_TEXT_ROWS = 15;
  localparam int COLS              = 32;
  localparam int COL_W             = 5;

  localparam logic [7:0] CELL_MARK   = 8'hEF;
  localparam logic [7:0] CELL_SPACE  = 8'h20;
  localparam logic [7:0] CELL_DASH   = 8'h2D;
  localparam logic [7:0] HILITE_BIT  = 8'h40;
  localparam logic [7:0] CODE_MASK   = 8'h3F;
  localparam logic [7:0] CASE_OFFSET = 8'd32;

  localparam logic [7:0] CH_HILITE = 8'd1;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_FIRST  = 8'd32;
  localparam logic [7:0] CH_LAST   = 8'd127;
  localparam logic [7:0] LOWER_LO  = 8'd96;
  localparam logic [7:0] LOWER_HI  = 8'd126;

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

endpackage

>>> design/text_screen_terminal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_screen_terminal
// Text screen of TEXT_ROWS x 32 cells with a cursor. Put requests draw one
// character; read requests return one cell.
//
// Input channel s_*: tuser = req_type (0 put, 1 read); tdata = char_code,
// cell_index. Output channel m_*: one transfer per request with cell_value
// (zero on put) and cursor_pos (low 9 bits of the cursor after the request).
// The cell store is a single-port-write, single-port-read memory with a
// registered read, driven by a small sequencer; one request at a time.
// After reset a clearing pass fills all TEXT_ROWS*32 cells with dash,
// and s_tready stays low until it ends. A CR/LF writes n (1 to 32) spaces
// from the cursor up to the row end. Running off the last cell scrolls the
// screen, one cell copied per cycle through the memory port. s_tready rises
// with m_tvalid.
// The result sits in an output register; while the receiver stalls the
// block finishes the next request and then waits for the output to drain.
// ----------------------------------------------------------------------------
module text_screen_terminal
  import txtscr_pkg::*;
#(
  parameter int TEXT_ROWS = DEFAULT_TEXT_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] char_code, [16:8] cell_index, [23:17] zero
  input  logic        s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [7:0] cell_value, [16:8] cursor_pos, [23:17] zero
);

  localparam int CELLS = TEXT_ROWS * COLS;
  localparam int CW    = $clog2(CELLS);

  localparam logic [CW-1:0] LAST_CELL = CW'(CELLS - 1);
  localparam logic [CW-1:0] LAST_ROW  = CW'(CELLS - COLS);
  localparam logic [CW-1:0] COPY_END  = CW'(CELLS - COLS - 1);
  localparam logic [CW-1:0] ROW_STEP  = CW'(COLS);

  typedef enum logic [3:0] {
    CLEAR, IDLE, DECODE, RD_WAIT, HL_WAIT, FILL,
    SCR_RD, SCR_CP, SCR_CLR, MARK, DONE
  } state_t;

  state_t        state;
  logic          req_r;
  logic [7:0]    code_r;
  logic [8:0]    idx_r;
  logic [CW-1:0] cursor;
  logic [CW-1:0] ptr;
  logic [7:0]    res_val;
  logic [7:0]    out_value;
  logic [8:0]    out_cursor;

  logic [7:0]    mem [CELLS];
  logic [7:0]    rdata;
  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  logic [CW-1:0] mem_raddr;
  logic [7:0]    mem_wdata;

  logic          idx_ok;
  logic          is_nl;
  logic          is_print;
  logic          at_start;
  logic [7:0]    folded;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  assign idx_ok   = 32'(idx_r) < 32'(CELLS);
  assign is_nl    = (code_r == CH_CR) || (code_r == CH_LF);
  assign is_print = (code_r >= CH_FIRST) && (code_r <= CH_LAST);
  assign at_start = (cursor == '0);

  always_comb begin
    folded = code_r;
    if (code_r inside {[LOWER_LO:LOWER_HI]}) begin
      folded = code_r - CASE_OFFSET;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cursor;
    mem_wdata = CELL_MARK;
    mem_raddr = cursor;
    case (state)
      CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = CELL_DASH;
      end
      DECODE: begin
        if (req_r == REQ_READ) begin
          mem_raddr = CW'(idx_r);
        end else if (code_r == CH_BS) begin
          mem_we    = !at_start;
          mem_wdata = CELL_SPACE;
        end else if (code_r == CH_HILITE) begin
          mem_raddr = cursor - 1'b1;
        end else if (is_print && !is_nl) begin
          mem_we    = 1'b1;
          mem_wdata = folded & CODE_MASK;
        end
      end
      HL_WAIT: begin
        mem_we    = 1'b1;
        mem_waddr = cursor - 1'b1;
        mem_wdata = rdata ^ HILITE_BIT;
      end
      FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = CELL_SPACE;
      end
      SCR_RD: begin
        mem_raddr = ptr + ROW_STEP;
      end
      SCR_CP: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = rdata;
        mem_raddr = ptr + ROW_STEP + 1'b1;
      end
      SCR_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = CELL_SPACE;
      end
      MARK: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CLEAR;
      ptr      <= '0;
      cursor   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        CLEAR: begin
          ptr <= ptr + 1'b1;
          if (ptr == LAST_CELL) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (s_tvalid) begin
            req_r  <= s_tuser;
            code_r <= s_tdata[7:0];
            idx_r  <= s_tdata[16:8];
            state  <= DECODE;
          end
        end
        DECODE: begin
          res_val <= '0;
          if (req_r == REQ_READ) begin
            state <= idx_ok ? RD_WAIT : DONE;
          end else if (is_nl) begin
            ptr   <= cursor;
            state <= FILL;
          end else if (code_r == CH_BS) begin
            if (!at_start) begin
              cursor <= cursor - 1'b1;
            end
            state <= MARK;
          end else if (code_r == CH_HILITE) begin
            state <= at_start ? MARK : HL_WAIT;
          end else if (is_print) begin
            if (cursor == LAST_CELL) begin
              ptr   <= '0;
              state <= SCR_RD;
            end else begin
              cursor <= cursor + 1'b1;
              state  <= MARK;
            end
          end else begin
            state <= DONE;
          end
        end
        RD_WAIT: begin
          res_val <= rdata;
          state   <= DONE;
        end
        HL_WAIT: begin
          state <= MARK;
        end
        FILL: begin
          if (ptr[COL_W-1:0] == COL_W'(COLS - 1)) begin
            if (ptr == LAST_CELL) begin
              ptr   <= '0;
              state <= SCR_RD;
            end else begin
              cursor <= ptr + 1'b1;
              state  <= MARK;
            end
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        SCR_RD: begin
          state <= SCR_CP;
        end
        SCR_CP: begin
          if (ptr == COPY_END) begin
            ptr   <= LAST_ROW;
            state <= SCR_CLR;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        SCR_CLR: begin
          if (ptr == LAST_CELL) begin
            cursor <= LAST_ROW;
            state  <= MARK;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        MARK: begin
          state <= DONE;
        end
        DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_value  <= res_val;
            out_cursor <= 9'(cursor);
            state      <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign s_tready = (state == IDLE);
  assign m_tdata  = {7'd0, out_cursor, out_value};

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for text_screen_terminal. A queue of put and read
// requests feeds a bursty stream driver; an internal screen image predicts
// cell_value and cursor_pos for each accepted request, and a monitor
// compares every output transfer against the oldest prediction while the
// output side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;
  import txtscr_pkg::*;

  localparam int          ROWS         = DEFAULT_TEXT_ROWS;
  localparam int          CELLS        = ROWS * COLS;
  localparam int          WORK_ITEMS   = 1150;
  localparam int          DRAIN_CYCLES = CELLS + 40;
  localparam int          LIMIT_CYCLES = 10000000;
  localparam int          MAX_PRINTS   = 100;
  localparam logic [7:0]  CH_NUL       = 8'd0;
  localparam logic [8:0]  IDX_MAX      = 9'h1FF;

  typedef struct packed {
    logic       req;
    logic [7:0] ch;
    logic [8:0] idx;
  } screen_req_t;

  typedef struct packed {
    logic [7:0] value;
    logic [8:0] cursor;
  } screen_rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [7:0] char_code, [16:8] cell_index, [23:17] zero
  logic        s_tuser = REQ_PUT;  // [0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [7:0] cell_value, [16:8] cursor_pos, [23:17] zero

  text_screen_terminal #(.TEXT_ROWS(ROWS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // screen image
  logic [7:0]  shadow_cells [CELLS];
  int unsigned shadow_cursor;

  screen_req_t req_backlog [$];
  screen_rsp_t cell_answers [$];
  screen_req_t tx_item;
  int unsigned tx_burst = 0;
  int unsigned tx_gap = 0;
  logic        tx_busy;
  int unsigned work_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned rx_hold = 0;
  int unsigned rx_mode = 0;
  logic        rx_next;

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("ERROR @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  function void shadow_clear();
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = CELL_DASH;
    shadow_cursor = 0;
  endfunction

  function void draw_glyph(input logic [7:0] code);
    int unsigned p;
    p = shadow_cursor;
    if (code >= LOWER_LO && code <= LOWER_HI) code = code - CASE_OFFSET;
    shadow_cells[p] = code & CODE_MASK;
    p++;
    if (p >= CELLS) begin
      for (int i = 0; i < CELLS - COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
      for (int i = CELLS - COLS; i < CELLS; i++) shadow_cells[i] = CELL_SPACE;
      p = CELLS - COLS;
    end
    shadow_cells[p] = CELL_MARK;
    shadow_cursor = p;
  endfunction

  function screen_rsp_t screen_apply(input screen_req_t r);
    screen_rsp_t rsp;
    rsp.value = '0;
    if (r.req == REQ_READ) begin
      if (r.idx < CELLS) rsp.value = shadow_cells[r.idx];
    end else if (r.ch == CH_CR || r.ch == CH_LF) begin
      do draw_glyph(CELL_SPACE); while ((shadow_cursor % COLS) != 0);
    end else if (r.ch == CH_BS) begin
      if (shadow_cursor > 0) begin
        shadow_cells[shadow_cursor] = CELL_SPACE;
        shadow_cursor--;
      end
      shadow_cells[shadow_cursor] = CELL_MARK;
    end else if (r.ch == CH_HILITE) begin
      if (shadow_cursor > 0) shadow_cells[shadow_cursor - 1] ^= HILITE_BIT;
      shadow_cells[shadow_cursor] = CELL_MARK;
    end else if (r.ch >= CH_FIRST && r.ch <= CH_LAST) begin
      draw_glyph(r.ch);
    end
    rsp.cursor = 9'(shadow_cursor);
    return rsp;
  endfunction

  task automatic queue_put(input logic [7:0] ch);
    screen_req_t r;
    r.req = REQ_PUT;
    r.ch  = ch;
    r.idx = 9'($urandom_range(0, IDX_MAX));
    req_backlog.push_back(r);
    work_cnt++;
  endtask

  task automatic queue_read(input int unsigned idx);
    screen_req_t r;
    r.req = REQ_READ;
    r.ch  = 8'($urandom);
    r.idx = 9'(idx);
    req_backlog.push_back(r);
    work_cnt++;
  endtask

  // control codes and high bytes that the block ignores
  task automatic queue_noise();
    screen_req_t r;
    r.req = REQ_PUT;
    r.idx = 9'($urandom_range(0, IDX_MAX));
    case ($urandom_range(0, 5))
      0: r.ch = CH_NUL;
      1: r.ch = 8'($urandom_range(CH_HILITE + 1, CH_BS - 1));
      2: r.ch = CH_BS + 8'd1;
      3: r.ch = 8'($urandom_range(CH_LF + 1, CH_CR - 1));
      4: r.ch = 8'($urandom_range(CH_CR + 1, CH_FIRST - 1));
      default: r.ch = 8'($urandom_range(CH_LAST + 1, 8'hFF));
    endcase
    req_backlog.push_back(r);
    work_cnt++;
  endtask

  task automatic queue_random_read();
    if ($urandom_range(0, 9) == 0) queue_read($urandom_range(CELLS, IDX_MAX));
    else queue_read($urandom_range(0, CELLS - 1));
  endtask

  task automatic queue_newline();
    queue_put(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_burst <= 0;
      tx_gap   <= 0;
    end else begin
      tx_busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        cell_answers.push_back(screen_apply(tx_item));
        tx_busy = 1'b0;
      end
      if (!tx_busy) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          tx_item = req_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {7'd0, tx_item.idx, tx_item.ch};
          s_tuser  <= tx_item.req;
          if (tx_burst <= 1) begin
            tx_burst <= $urandom_range(1, 30);
            case ($urandom_range(0, 7))
              0, 1, 2: tx_gap <= 0;
              3:       tx_gap <= $urandom_range(100, 700);
              default: tx_gap <= $urandom_range(1, 40);
            endcase
          end else begin
            tx_burst <= tx_burst - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output stall pattern
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold  <= 0;
      rx_mode  <= 0;
    end else begin
      if (cycle_cnt % 256 == 0) rx_mode <= $urandom_range(0, 2);
      if (rx_hold != 0) begin
        rx_hold <= rx_hold - 1;
      end else begin
        case (rx_mode)
          0: begin
            rx_next = 1'b1;
            rx_hold <= 0;
          end
          1: begin
            rx_next = ($urandom_range(0, 3) != 0);
            rx_hold <= $urandom_range(0, 2);
          end
          default: begin
            rx_next = !m_tready;
            rx_hold <= m_tready ? $urandom_range(0, 40) : $urandom_range(0, 4);
          end
        endcase
        m_tready <= rx_next;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (cell_answers.size() == 0) begin
        report_mismatch("unexpected transfer", m_tdata, 0);
      end else begin
        screen_rsp_t want;
        want = cell_answers.pop_front();
        if (m_tdata[7:0] != want.value)
          report_mismatch("cell_value", m_tdata[7:0], want.value);
        if (m_tdata[16:8] != want.cursor)
          report_mismatch("cursor_pos", m_tdata[16:8], want.cursor);
        if (m_tdata[23:17] != '0)
          report_mismatch("tdata pad", m_tdata[23:17], 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned sel;
    int unsigned len;
    shadow_clear();

    // directed: reads at the edges, start-of-screen controls, folding, ignored codes
    queue_read(0);
    queue_read(CELLS - 1);
    queue_read(CELLS);
    queue_read(IDX_MAX);
    queue_put(CH_BS);
    queue_put(CH_HILITE);
    queue_put(LOWER_LO + 8'd1);
    queue_put(LOWER_LO);
    queue_put(LOWER_HI);
    queue_put(CH_LAST);
    queue_put(CH_FIRST);
    queue_put(LOWER_LO - 8'd1);
    queue_put(CH_HILITE);
    queue_put(CH_BS);
    queue_noise();
    queue_noise();
    queue_noise();
    queue_put(CH_CR);
    queue_put(CH_LF);
    queue_read(0);
    queue_read(1);
    queue_read(2);
    queue_read(COLS);
    queue_read(2 * COLS);

    while (work_cnt < WORK_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel < 10) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 70) : $urandom_range(0, 32);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 19))
            0:       queue_put(CH_BS);
            1:       queue_put(CH_HILITE);
            2:       queue_random_read();
            default: queue_put(8'($urandom_range(CH_FIRST, CH_LAST)));
          endcase
        end
        queue_newline();
      end else if (sel < 13) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) queue_random_read();
      end else if (sel < 15) begin
        len = $urandom_range(1, 16);
        for (int i = 0; i < len; i++) queue_newline();
      end else if (sel == 15) begin
        len = $urandom_range(1, 40);
        for (int i = 0; i < len; i++) queue_put(CH_BS);
      end else if (sel == 16) begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) queue_put(CH_HILITE);
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) queue_noise();
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (req_backlog.size() != 0 || s_tvalid || cell_answers.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0 && cell_answers.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
design/txtscr_pkg.sv
design/text_screen_terminal.sv
tb/tb_top.sv
